### rtl/dmlc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dmlc_pkg;

   // Cache geometry. Both counts are powers of two.
   localparam int LINE_BYTES = 16;
   localparam int NUM_LINES  = 64;

   localparam int OFF_W  = $clog2(LINE_BYTES);
   localparam int SLOT_W = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;

   // Item field widths.
   localparam int ADDR_W  = 32;
   localparam int SIZE_W  = 3;
   localparam int WORD_W  = 32;
   localparam int TAG_W   = 28;
   localparam int FILL_W  = 64;
   localparam int MODE_W  = 2;
   localparam int REQ_DATA_W = 160;
   localparam int RSP_DATA_W = 32;

   // Largest access in bytes.
   localparam int MAX_ACCESS = 4;

   typedef enum logic [MODE_W-1:0] {
      MODE_READ  = 2'd0,
      MODE_WRITE = 2'd1,
      MODE_FILL  = 2'd2
   } mode_type;

   typedef enum logic {
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   // One cache line, byte k of the line at index k.
   typedef logic [LINE_BYTES-1:0][7:0] line_type;

   // Write request to the line data memory, with byte enables.
   typedef struct packed {
      logic                  en;
      logic [SLOT_W-1:0]     slot;
      logic [LINE_BYTES-1:0] be;
      line_type              line;
   } data_wr_type;

   // Fill update to the tag memory and valid bits.
   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] slot;
      logic              last;
      logic [TAG_W-1:0]  tag;
   } tag_wr_type;

   // A captured input item.
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [ADDR_W-1:0] address;
      logic [SIZE_W-1:0] access_size;
      logic [WORD_W-1:0] write_data;
      logic [TAG_W-1:0]  line_number;
      logic              chunk_index;
      logic [FILL_W-1:0] fill_data;
      logic              fill_last;
   } req_type;

   // Slot of a byte address.
   function automatic logic [SLOT_W-1:0] slot_of_addr(input logic [ADDR_W-1:0] addr);
      logic [ADDR_W-1:0] num;
      num = addr >> OFF_W;
      return SLOT_W'(num % NUM_LINES);
   endfunction

   // Slot of a line number.
   function automatic logic [SLOT_W-1:0] slot_of_line(input logic [TAG_W-1:0] num);
      return SLOT_W'(num % NUM_LINES);
   endfunction

endpackage

`default_nettype wire

### rtl/dmlc_data_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module dmlc_data_ram
   import dmlc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              rd_en,
   input  wire logic [SLOT_W-1:0] rd_slot,
   output line_type               rd_line,
   input  wire data_wr_type       wr
);

   line_type line_mem [NUM_LINES];
   line_type rd_line_ff;

   // Synchronous read of one whole line.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_line_ff <= line_mem[rd_slot];
      end
   end

   // Byte-enabled write of one line.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         for (int b = 0; b < LINE_BYTES; b++) begin
            if (wr.be[b]) begin
               line_mem[wr.slot][b] <= wr.line[b];
            end
         end
      end
   end

   assign rd_line = rd_line_ff;

endmodule

`default_nettype wire

### rtl/dmlc_tag_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module dmlc_tag_ram
   import dmlc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              rd_en,
   input  wire logic [SLOT_W-1:0] rd_slot,
   output logic [TAG_W-1:0]       rd_tag,
   output logic                   rd_valid,
   input  wire tag_wr_type        wr
);

   logic [TAG_W-1:0]     tag_mem [NUM_LINES];
   logic [NUM_LINES-1:0] valid_ff;
   logic [NUM_LINES-1:0] valid_in;
   logic [TAG_W-1:0]     rd_tag_ff;
   logic                 rd_valid_ff;

   // A last chunk validates the slot; any other chunk invalidates it.
   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr.slot] = wr.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // The tag is stored only with the last chunk.
   always_ff @(posedge clock) begin
      if (wr.en && wr.last) begin
         tag_mem[wr.slot] <= wr.tag;
      end
   end

   // Registered read of tag and valid bit together.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_tag_ff   <= tag_mem[rd_slot];
         rd_valid_ff <= valid_ff[rd_slot];
      end
   end

   assign rd_tag   = rd_tag_ff;
   assign rd_valid = rd_valid_ff;

endmodule

`default_nettype wire

### rtl/direct_mapped_line_cache.sv
`timescale 1ns / 1ps
`default_nettype none

// Direct-mapped cache of NUM_LINES lines of LINE_BYTES bytes, held in a line
// data memory and a tag memory, both with registered reads, plus a valid bit
// per line that reset clears. An item is taken in ST_IDLE, where the tag and
// line memories are read at its slot; in ST_LOOKUP it compares, assembles the
// big-endian read value or merges write and fill bytes, and writes back. One
// item is in flight at a time, and no new item is taken until it finishes; the
// result register lets the next item enter while a result still waits, and
// the block waits in ST_LOOKUP only while that register is full and not
// drained. Reads and writes of up to 4 bytes hit on a valid matching line
// that they do not run past; fill chunks always answer with hit set.
module direct_mapped_line_cache
   import dmlc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Input items.
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // address[31:0], access_size[34:32], write_data[66:35], line_number[94:67],
   // chunk_index[95], fill_data[159:96]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // mode[1:0]
   input  wire logic [MODE_W-1:0]     req_tuser,
   // fill_last
   input  wire logic                  req_tlast,
   // Result items.
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // read_data[31:0]
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // hit[0]
   output logic [0:0]                 rsp_tuser
);

   state_type         state_ff, state_in;
   req_type           req_ff, req_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_hit_ff, rsp_hit_in;
   logic [WORD_W-1:0] rsp_data_ff, rsp_data_in;

   logic              accept;
   logic              finish;
   logic [SLOT_W-1:0] rd_slot;
   line_type          rd_line;
   logic [TAG_W-1:0]  rd_tag;
   logic              rd_valid;
   data_wr_type       data_wr;
   tag_wr_type        tag_wr;

   logic [OFF_W-1:0]  off;
   logic [SIZE_W-1:0] size;
   logic              tag_match;
   logic              size_ok;
   logic              in_line;
   logic              hit_rw;
   logic [5:0]        shamt;
   logic [WORD_W-1:0] read_word;
   logic [WORD_W-1:0] read_value;
   logic [3:0][7:0]   write_bytes;
   logic [7:0][7:0]   fill_bytes;
   logic [OFF_W-1:0]  idx;
   logic [OFF_W-1:0]  rel_pos;

   // Unpack the input item.
   always_comb begin
      req_in = req_ff;
      if (accept) begin
         req_in.mode        = req_tuser;
         req_in.address     = req_tdata[31:0];
         req_in.access_size = req_tdata[34:32];
         req_in.write_data  = req_tdata[66:35];
         req_in.line_number = req_tdata[94:67];
         req_in.chunk_index = req_tdata[95];
         req_in.fill_data   = req_tdata[159:96];
         req_in.fill_last   = req_tlast;
      end
   end

   // Sequencer: take an item, then finish it once the result register is free.
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      accept     = 1'b0;
      finish     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            accept     = req_tvalid;
            if (req_tvalid) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            finish = !rsp_valid_ff || rsp_tready;
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rd_slot = slot_of_addr(req_tdata[31:0]);

   dmlc_tag_ram u_tag_ram (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_slot  (rd_slot),
      .rd_tag   (rd_tag),
      .rd_valid (rd_valid),
      .wr       (tag_wr)
   );

   dmlc_data_ram u_data_ram (
      .clock   (clock),
      .rd_en   (accept),
      .rd_slot (rd_slot),
      .rd_line (rd_line),
      .wr      (data_wr)
   );

   // Hit check on the captured item.
   always_comb begin
      off       = req_ff.address[OFF_W-1:0];
      size      = req_ff.access_size;
      tag_match = rd_valid && (ADDR_W'(rd_tag) == (req_ff.address >> OFF_W));
      size_ok   = size <= SIZE_W'(MAX_ACCESS);
      in_line   = ((OFF_W+1)'(off) + (OFF_W+1)'(size)) <= (OFF_W+1)'(LINE_BYTES);
      hit_rw    = tag_match && size_ok && in_line;
      shamt     = {3'(3'(MAX_ACCESS) - size), 3'b000};
   end

   // Big-endian read assembly: first byte into the top of the word, then align.
   always_comb begin
      read_word = '0;
      idx       = '0;
      for (int i = 0; i < MAX_ACCESS; i++) begin
         idx = off + OFF_W'(i);
         read_word[WORD_W-1-8*i -: 8] = rd_line[idx];
      end
      if (size == '0) begin
         read_value = '0;
      end else begin
         read_value = read_word >> shamt;
      end
   end

   // Byte merge for writes and fill chunks.
   always_comb begin
      write_bytes  = req_ff.write_data << shamt;
      fill_bytes   = req_ff.fill_data;
      rel_pos      = '0;
      data_wr      = '0;
      data_wr.slot = slot_of_addr(req_ff.address);
      case (req_ff.mode)
         MODE_WRITE: begin
            data_wr.en = finish && hit_rw;
            for (int b = 0; b < LINE_BYTES; b++) begin
               rel_pos = OFF_W'(b) - off;
               if ((OFF_W'(b) >= off) && ((OFF_W+1)'(rel_pos) < (OFF_W+1)'(size))) begin
                  data_wr.be[b] = 1'b1;
               end
               data_wr.line[b] = write_bytes[2'd3 - rel_pos[1:0]];
            end
         end
         MODE_FILL: begin
            data_wr.en   = finish;
            data_wr.slot = slot_of_line(req_ff.line_number);
            for (int b = 0; b < LINE_BYTES; b++) begin
               if (32'(req_ff.chunk_index) == b / 8) begin
                  data_wr.be[b] = 1'b1;
               end
               data_wr.line[b] = fill_bytes[7 - (b % 8)];
            end
         end
         default: begin
            data_wr.en = 1'b0;
         end
      endcase
   end

   // Tag and valid update on every fill chunk.
   always_comb begin
      tag_wr.en   = finish && (req_ff.mode == MODE_FILL);
      tag_wr.slot = slot_of_line(req_ff.line_number);
      tag_wr.last = req_ff.fill_last;
      tag_wr.tag  = req_ff.line_number;
   end

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_hit_in   = rsp_hit_ff;
      rsp_data_in  = rsp_data_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         case (req_ff.mode)
            MODE_READ: begin
               rsp_hit_in = hit_rw;
               if (hit_rw) begin
                  rsp_data_in = read_value;
               end
            end
            MODE_WRITE: begin
               rsp_hit_in = hit_rw;
            end
            MODE_FILL: begin
               rsp_hit_in = 1'b1;
            end
            default: begin
               rsp_hit_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_hit_ff;

   // An accepted item always moves on to the lookup cycle.
   a_accept_lookup: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_LOOKUP)
      else $error("accepted item did not enter lookup");

   // Memory writes happen only while an item is being finished.
   a_write_in_lookup: assert property (@(posedge clock) disable iff (reset)
      (data_wr.en || tag_wr.en) |-> (state_ff == ST_LOOKUP && finish))
      else $error("memory write outside lookup");

   // A fill chunk always answers with hit set.
   a_fill_hit: assert property (@(posedge clock) disable iff (reset)
      (finish && req_ff.mode == MODE_FILL) |=> (rsp_tvalid && rsp_tuser[0]))
      else $error("fill item did not answer hit");

   // A miss never carries read data.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> rsp_tdata == '0)
      else $error("miss with nonzero read data");

endmodule

`default_nettype wire
